// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-check wrappers, clocked on clk and held off by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define BTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define BTS_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- rtl/bts_pkg.sv -----
// ----------------------------------------------------------------------------
// bts_pkg
// Constants, item types and register codes of the bilinear texture sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bts_pkg;

    // Texel store geometry
    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 256;
    localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths
    localparam int IDX_W     = 8;              // column / row index fields
    localparam int COORD_W   = 18;             // signed Q2.16
    localparam int FRAC_W    = 16;
    localparam int UNIT_W    = FRAC_W + 1;     // clamped coordinate 0..1.0
    localparam int CHAN_W    = 8;
    localparam int NUM_CH    = 3;
    localparam int NUM_TAPS  = 4;
    localparam int TEXEL_W   = NUM_CH * CHAN_W;
    localparam int WEIGHT_W  = 2 * FRAC_W + 1; // Q1.32 weight, up to 1.0
    localparam int OUT_SHIFT = 2 * FRAC_W - CHAN_W;
    localparam int ACC_W     = 2 * FRAC_W + CHAN_W;
    localparam int OUT_W     = 16;

    localparam logic [UNIT_W-1:0] ONE_Q16    = UNIT_W'(1) << FRAC_W;
    localparam logic [OUT_W-1:0]  FULL_SCALE = OUT_W'(8'hFF) << CHAN_W;
    localparam logic [ACC_W-1:0]  ROUND_BIAS = ACC_W'(1) << (OUT_SHIFT - 1);

    // Stream widths
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = NUM_CH * OUT_W;

    // Operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_COLUMN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_ROW        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_PRESENT = 2'd2;

    // Result queue
    localparam int RES_PTR_W = 3;
    localparam int RES_DEPTH = 1 << RES_PTR_W;
    localparam int RES_CNT_W = RES_PTR_W + 1;

    // Input item as unpacked from the stream
    typedef struct packed {
        logic                     op;
        logic [IDX_W-1:0]         col;
        logic [IDX_W-1:0]         row;
        logic [TEXEL_W-1:0]       texel;
        logic signed [COORD_W-1:0] u;
        logic signed [COORD_W-1:0] v;
    } bts_item_t;

    // Store request: a texel write or a sample's base corner and fractions
    typedef struct packed {
        logic               op;
        logic               present;
        logic [IDX_W-1:0]   col;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   lc;
        logic [IDX_W-1:0]   lr;
        logic [TEXEL_W-1:0] texel;
        logic [FRAC_W-1:0]  du;
        logic [FRAC_W-1:0]  dv;
    } bts_req_t;

    // Four neighbour texels, order c00, c10, c01, c11
    typedef struct packed {
        logic                             valid;
        logic                             present;
        logic [FRAC_W-1:0]                du;
        logic [FRAC_W-1:0]                dv;
        logic [NUM_TAPS-1:0][TEXEL_W-1:0] texel;
    } bts_quad_t;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } bts_result_t;

endpackage

// ----- rtl/bilinear_texture_sampler_unit.sv -----
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_unit
// Bilinear RGB888 texture sampler with an on-chip texel store.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_t*; s_tuser selects a texel write or a sample.
//   A write stores one texel and yields nothing; a sample yields one RGB
//   result in 8.8 fixed point on m_t*. Results leave in input order.
//   The cfg port sets last column, last row and texture present; write it
//   only while no item is in flight.
// Flow:
//   A sample reads its four neighbours over the two read ports, upper pair
//   and then lower pair; a write needs one store access. The store takes a
//   new request once the current one is done, while the next item may wait
//   in the input and scaling registers. Results pass the filter stages.
// Reset and stall:
//   Reset clears the configuration registers and all control state; the texel
//   store is not cleared and holds garbage until written. An 8-entry result
//   queue absorbs stalls on m_tready; with 8 samples owed, s_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bilinear_texture_sampler_unit
    import bts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // texel_column[7:0], texel_row[15:8], red_in[23:16], green_in[31:24],
    // blue_in[39:32], u_coord[57:40], v_coord[75:58], zero [79:76]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // operation[0]
    input  logic [0:0]           s_tuser,
    // Result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // red_out[15:0], green_out[31:16], blue_out[47:32]
    output logic [M_TDATA_W-1:0] m_tdata,
    // Configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [IDX_W-1:0]     cfg_data
);

    logic [IDX_W-1:0] last_column_reg, last_column_next;
    logic [IDX_W-1:0] last_row_reg, last_row_next;
    logic             present_reg, present_next;
    logic [IDX_W-1:0] lc, lr;

    logic [RES_CNT_W-1:0] credit_reg, credit_next;
    logic sample_in, result_out, in_accept;

    bts_item_t   in_item;
    logic        coord_ready;
    logic        req_valid, req_ready;
    bts_req_t    req;
    bts_quad_t   quad;
    bts_result_t res;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        last_column_next = last_column_reg;
        last_row_next    = last_row_reg;
        present_next     = present_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LAST_COLUMN:     last_column_next = cfg_data;
                REG_LAST_ROW:        last_row_next    = cfg_data;
                REG_TEXTURE_PRESENT: present_next     = cfg_data[0];
                default:             present_next     = present_reg;
            endcase
        end
    end

    // Last indexes limited to the store size
    assign lc = (32'(last_column_reg) < MAX_COLUMNS) ? last_column_reg
                                                     : IDX_W'(MAX_COLUMNS - 1);
    assign lr = (32'(last_row_reg) < MAX_ROWS) ? last_row_reg
                                               : IDX_W'(MAX_ROWS - 1);

    // Unpack the input item
    always_comb
    begin
        in_item.op    = s_tuser[0];
        in_item.col   = s_tdata[7:0];
        in_item.row   = s_tdata[15:8];
        in_item.texel = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
        in_item.u     = s_tdata[57:40];
        in_item.v     = s_tdata[75:58];
    end

    // Credits: samples accepted whose result has not yet left
    assign s_tready   = coord_ready && (credit_reg < RES_CNT_W'(RES_DEPTH));
    assign in_accept  = s_tvalid && s_tready;
    assign sample_in  = in_accept && (s_tuser[0] == OP_SAMPLE);
    assign result_out = m_tvalid && m_tready;

    always_comb
    begin
        case ({sample_in, result_out})
            2'b10:   credit_next = credit_reg + 1'b1;
            2'b01:   credit_next = credit_reg - 1'b1;
            default: credit_next = credit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_column_reg <= '0;
            last_row_reg    <= '0;
            present_reg     <= 1'b0;
            credit_reg      <= '0;
        end
        else
        begin
            last_column_reg <= last_column_next;
            last_row_reg    <= last_row_next;
            present_reg     <= present_next;
            credit_reg      <= credit_next;
        end
    end

    bts_coord u_coord
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_accept),
        .in_item   (in_item),
        .in_ready  (coord_ready),
        .lc        (lc),
        .lr        (lr),
        .present   (present_reg),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready)
    );

    bts_fetch u_fetch
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready),
        .quad      (quad)
    );

    bts_filter u_filter
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .quad      (quad),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {res.blue, res.green, res.red};

    `BTS_NEVER(a_credit_range, credit_reg > RES_CNT_W'(RES_DEPTH), "credit count above queue depth")
    `BTS_ASSERT(a_result_owed, m_tvalid |-> (credit_reg != '0), "result offered with no sample owed")
    `BTS_ASSERT(a_credit_stop, (credit_reg == RES_CNT_W'(RES_DEPTH)) |-> !s_tready, "input open with queue fully owed")

endmodule

// ----- rtl/bts_coord.sv -----
// ----------------------------------------------------------------------------
// bts_coord
// Input register, coordinate clamp and scaling to base corner and fractions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bts_coord
    import bts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  bts_item_t in_item,
    output logic      in_ready,
    input  logic [IDX_W-1:0] lc,
    input  logic [IDX_W-1:0] lr,
    input  logic      present,
    output logic      req_valid,
    output bts_req_t  req,
    input  logic      req_ready
);

    localparam int PROD_W = UNIT_W + IDX_W;

    logic      s0_valid_reg, s0_valid_next;
    bts_item_t s0_item_reg;
    logic      s1_valid_reg, s1_valid_next;
    bts_req_t  s1_req_reg, s1_req_next;
    logic      s0_load, s1_load;
    logic [UNIT_W-1:0] u_clamp, v_flip;
    logic [PROD_W-1:0] u_scaled, v_scaled;

    // Clamp signed Q2.16 to 0..1.0
    function automatic logic [UNIT_W-1:0] clamp_coord(input logic [COORD_W-1:0] raw);
        logic [UNIT_W-1:0] mag;
        mag = raw[UNIT_W-1:0];
        if (raw[COORD_W-1])
            return '0;
        else if (mag > ONE_Q16)
            return ONE_Q16;
        else
            return mag;
    endfunction

    // Stage advance
    assign s1_load  = !s1_valid_reg || req_ready;
    assign s0_load  = !s0_valid_reg || s1_load;
    assign in_ready = s0_load;

    assign s0_valid_next = s0_load ? in_valid : s0_valid_reg;
    assign s1_valid_next = s1_load ? s0_valid_reg : s1_valid_reg;

    // Scale clamped coordinates by the last index
    always_comb
    begin
        u_clamp  = clamp_coord(s0_item_reg.u);
        v_flip   = ONE_Q16 - clamp_coord(s0_item_reg.v);
        u_scaled = PROD_W'(u_clamp) * PROD_W'(lc);
        v_scaled = PROD_W'(v_flip) * PROD_W'(lr);

        s1_req_next.op      = s0_item_reg.op;
        s1_req_next.present = present;
        s1_req_next.lc      = lc;
        s1_req_next.lr      = lr;
        s1_req_next.texel   = s0_item_reg.texel;
        s1_req_next.du      = u_scaled[FRAC_W-1:0];
        s1_req_next.dv      = v_scaled[FRAC_W-1:0];
        if (s0_item_reg.op == OP_WRITE)
        begin
            s1_req_next.col = s0_item_reg.col;
            s1_req_next.row = s0_item_reg.row;
        end
        else
        begin
            s1_req_next.col = u_scaled[FRAC_W +: IDX_W];
            s1_req_next.row = v_scaled[FRAC_W +: IDX_W];
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s0_load)
            s0_item_reg <= in_item;
        if (s1_load)
            s1_req_reg <= s1_req_next;
    end

    assign req_valid = s1_valid_reg;
    assign req       = s1_req_reg;

endmodule

// ----- rtl/bts_fetch.sv -----
// ----------------------------------------------------------------------------
// bts_fetch
// Texel store with one write and two read ports. A sample reads its upper
// pair of neighbours first and its lower pair in the next cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bts_fetch
    import bts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  bts_req_t  req,
    output logic      req_ready,
    output bts_quad_t quad
);

    logic [TEXEL_W-1:0] mem [STORE_DEPTH];

    logic         iss_valid_reg, iss_valid_next;
    logic         iss_phase_reg, iss_phase_next;
    bts_req_t     iss_req_reg;
    logic         iss_done, iss_sample, iss_second;
    logic [IDX_W-1:0] col_next, row_next, row_sel;
    logic [ADDR_W-1:0] addr_a, addr_b;
    logic         wr_en;
    logic [TEXEL_W-1:0] rdata_a_reg, rdata_b_reg;
    logic [TEXEL_W-1:0] hold_a_reg, hold_b_reg;
    logic         rd_valid_reg;
    logic         rd_present_reg;
    logic [FRAC_W-1:0] rd_du_reg, rd_dv_reg;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] c,
                                                  input logic [IDX_W-1:0] r);
        return ADDR_W'(r) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(c);
    endfunction

    // Issue control: a write is done in its first phase, a sample after its lower-pair read
    assign iss_sample = iss_valid_reg && (iss_req_reg.op == OP_SAMPLE);
    assign iss_second = iss_sample && iss_phase_reg;
    assign iss_done   = iss_valid_reg && ((iss_req_reg.op == OP_WRITE) || iss_phase_reg);
    assign req_ready  = !iss_valid_reg || iss_done;

    always_comb
    begin
        iss_valid_next = iss_valid_reg;
        iss_phase_next = iss_phase_reg;
        if (req_ready)
        begin
            iss_valid_next = req_valid;
            iss_phase_next = 1'b0;
        end
        else if (iss_valid_reg)
        begin
            iss_phase_next = 1'b1;
        end
    end

    // Neighbour indexes, clamped at the last column and row
    always_comb
    begin
        col_next = (iss_req_reg.col < iss_req_reg.lc) ? iss_req_reg.col + 1'b1
                                                      : iss_req_reg.col;
        row_next = (iss_req_reg.row < iss_req_reg.lr) ? iss_req_reg.row + 1'b1
                                                      : iss_req_reg.row;
        row_sel  = iss_phase_reg ? row_next : iss_req_reg.row;
        addr_a   = addr_of(iss_req_reg.col, row_sel);
        addr_b   = addr_of(col_next, row_sel);
        wr_en    = iss_valid_reg && (iss_req_reg.op == OP_WRITE)
                   && (32'(iss_req_reg.col) < MAX_COLUMNS)
                   && (32'(iss_req_reg.row) < MAX_ROWS);
    end

    // Texel store; a write goes through port A, whose address is then the texel's
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr_a] <= iss_req_reg.texel;
        rdata_a_reg <= mem[addr_a];
        rdata_b_reg <= mem[addr_b];
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_valid_reg <= 1'b0;
            iss_phase_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            iss_valid_reg <= iss_valid_next;
            iss_phase_reg <= iss_phase_next;
            rd_valid_reg  <= iss_second;
        end
    end

    // Payload: upper pair is held while the lower pair is read
    always_ff @(posedge clk)
    begin
        if (req_ready)
            iss_req_reg <= req;
        if (iss_second)
        begin
            hold_a_reg     <= rdata_a_reg;
            hold_b_reg     <= rdata_b_reg;
            rd_present_reg <= iss_req_reg.present;
            rd_du_reg      <= iss_req_reg.du;
            rd_dv_reg      <= iss_req_reg.dv;
        end
    end

    always_comb
    begin
        quad.valid    = rd_valid_reg;
        quad.present  = rd_present_reg;
        quad.du       = rd_du_reg;
        quad.dv       = rd_dv_reg;
        quad.texel[0] = hold_a_reg;
        quad.texel[1] = hold_b_reg;
        quad.texel[2] = rdata_a_reg;
        quad.texel[3] = rdata_b_reg;
    end

    `BTS_ASSERT(a_phase_sample, iss_phase_reg |-> iss_sample, "read phase without a sample")
    `BTS_ASSERT(a_quad_after_pair, rd_valid_reg |-> $past(iss_second), "quad without lower pair")

endmodule

// ----- rtl/bts_filter.sv -----
// ----------------------------------------------------------------------------
// bts_filter
// Bilinear weights, weighted channel sums, rounding to 8.8 and result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bts_filter
    import bts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  bts_quad_t   quad,
    output logic        res_valid,
    input  logic        res_ready,
    output bts_result_t res
);

    localparam int FULL_PROD_W = WEIGHT_W + CHAN_W;

    // Stage 1: weights
    logic                             f1_valid_reg;
    logic                             f1_present_reg;
    logic [NUM_TAPS-1:0][TEXEL_W-1:0] f1_texel_reg;
    logic [NUM_TAPS-1:0][WEIGHT_W-1:0] f1_weight_reg, f1_weight_next;
    logic [UNIT_W-1:0] inv_du, inv_dv;
    logic [2*UNIT_W-1:0] w00_full, w10_full, w01_full, w11_full;

    // Stage 2: products
    logic f2_valid_reg, f2_present_reg;
    logic [NUM_CH-1:0][NUM_TAPS-1:0][ACC_W-1:0]       f2_prod_reg;
    logic [NUM_CH-1:0][NUM_TAPS-1:0][FULL_PROD_W-1:0] prod_full;

    // Stage 3: pair sums
    logic f3_valid_reg, f3_present_reg;
    logic [NUM_CH-1:0][1:0][ACC_W-1:0] f3_sum_reg, f3_sum_next;
    logic [NUM_CH-1:0][ACC_W-1:0]      acc;
    logic [NUM_CH-1:0][OUT_W-1:0]      chan;
    bts_result_t push_res;

    // Result queue
    bts_result_t fifo_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RES_CNT_W-1:0] fifo_cnt_reg, fifo_cnt_next;
    logic push, pop;

    // Weights from the fractions
    always_comb
    begin
        inv_du   = ONE_Q16 - UNIT_W'(quad.du);
        inv_dv   = ONE_Q16 - UNIT_W'(quad.dv);
        w00_full = (2*UNIT_W)'(inv_du) * (2*UNIT_W)'(inv_dv);
        w10_full = (2*UNIT_W)'(quad.du) * (2*UNIT_W)'(inv_dv);
        w01_full = (2*UNIT_W)'(inv_du) * (2*UNIT_W)'(quad.dv);
        w11_full = (2*UNIT_W)'(quad.du) * (2*UNIT_W)'(quad.dv);
        f1_weight_next[0] = w00_full[WEIGHT_W-1:0];
        f1_weight_next[1] = w10_full[WEIGHT_W-1:0];
        f1_weight_next[2] = w01_full[WEIGHT_W-1:0];
        f1_weight_next[3] = w11_full[WEIGHT_W-1:0];
    end

    // Weight times channel byte, red in the top byte of a texel
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            for (int k = 0; k < NUM_TAPS; k++)
            begin
                prod_full[ch][k] = FULL_PROD_W'(f1_weight_reg[k])
                    * FULL_PROD_W'(f1_texel_reg[k][TEXEL_W-1-CHAN_W*ch -: CHAN_W]);
            end
        end
    end

    // Pair sums
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            f3_sum_next[ch][0] = f2_prod_reg[ch][0] + f2_prod_reg[ch][1];
            f3_sum_next[ch][1] = f2_prod_reg[ch][2] + f2_prod_reg[ch][3];
        end
    end

    // Final sum, round half up to 8.8; cyan when no texture is loaded
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            acc[ch]  = f3_sum_reg[ch][0] + f3_sum_reg[ch][1] + ROUND_BIAS;
            chan[ch] = acc[ch][OUT_SHIFT +: OUT_W];
        end
        if (f3_present_reg)
        begin
            push_res.red   = chan[0];
            push_res.green = chan[1];
            push_res.blue  = chan[2];
        end
        else
        begin
            push_res.red   = '0;
            push_res.green = FULL_SCALE;
            push_res.blue  = FULL_SCALE;
        end
    end

    assign push = f3_valid_reg;
    assign pop  = res_valid && res_ready;

    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg;
        case ({push, pop})
            2'b10:   fifo_cnt_next = fifo_cnt_reg + 1'b1;
            2'b01:   fifo_cnt_next = fifo_cnt_reg - 1'b1;
            default: fifo_cnt_next = fifo_cnt_reg;
        endcase
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            f1_valid_reg <= quad.valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            fifo_cnt_reg <= fifo_cnt_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (quad.valid)
        begin
            f1_present_reg <= quad.present;
            f1_texel_reg   <= quad.texel;
            f1_weight_reg  <= f1_weight_next;
        end
        if (f1_valid_reg)
        begin
            f2_present_reg <= f1_present_reg;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                for (int k = 0; k < NUM_TAPS; k++)
                begin
                    f2_prod_reg[ch][k] <= prod_full[ch][k][ACC_W-1:0];
                end
            end
        end
        if (f2_valid_reg)
        begin
            f3_present_reg <= f2_present_reg;
            f3_sum_reg     <= f3_sum_next;
        end
        if (push)
            fifo_mem[wr_ptr_reg] <= push_res;
    end

    assign res_valid = (fifo_cnt_reg != '0);
    assign res       = fifo_mem[rd_ptr_reg];

    `BTS_NEVER(a_queue_overflow, push && !pop && (fifo_cnt_reg == RES_CNT_W'(RES_DEPTH)), "result queue overflow")

endmodule
